[hdl/cbm_pkg.sv]
package cbm_pkg;

    // controller counter width, wide enough for any step count in range
    localparam int CNT_W = 5;

    localparam int ATAN_LEN    = 24;
    localparam int CORDIC_FRAC = 20;
    localparam int VEC_INT     = 30;
    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

    localparam logic [1:0] CFG_HALF_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HALF_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_SENSITIVITY = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DX,
        S_DY,
        S_MOD,
        S_FIX,
        S_CINIT,
        S_CSTEP,
        S_CSAVE,
        S_MUL,
        S_OUT
    } t_state;

    typedef struct packed {
        logic             accept;
        logic             dx;
        logic             dy;
        logic             mod_step;
        logic             fix;
        logic             cinit;
        logic             cstep;
        logic             csave;
        logic             mul;
        logic             out_load;
        logic             sel_pitch;
        logic [CNT_W-1:0] idx;
    } t_cmd;

    // arctangent of 2^-i in degrees, 20 fraction bits
    function automatic logic [26:0] atan_q20(input logic [CNT_W-1:0] i);
        logic [26:0] v;
        case (i)
            5'd0:    v = 27'd47185920;
            5'd1:    v = 27'd27855475;
            5'd2:    v = 27'd14718068;
            5'd3:    v = 27'd7471121;
            5'd4:    v = 27'd3750058;
            5'd5:    v = 27'd1876857;
            5'd6:    v = 27'd938658;
            5'd7:    v = 27'd469357;
            5'd8:    v = 27'd234682;
            5'd9:    v = 27'd117342;
            5'd10:   v = 27'd58671;
            5'd11:   v = 27'd29335;
            5'd12:   v = 27'd14668;
            5'd13:   v = 27'd7334;
            5'd14:   v = 27'd3667;
            5'd15:   v = 27'd1833;
            5'd16:   v = 27'd917;
            5'd17:   v = 27'd458;
            5'd18:   v = 27'd229;
            5'd19:   v = 27'd115;
            5'd20:   v = 27'd57;
            5'd21:   v = 27'd29;
            5'd22:   v = 27'd14;
            5'd23:   v = 27'd7;
            default: v = 27'd0;
        endcase
        return v;
    endfunction

endpackage

[hdl/cbm_ctrl.sv]
module cbm_ctrl #(
    parameter int MOD_STEPS = 15,
    parameter int NSTEPS    = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    output cbm_pkg::t_cmd o_cmd
);

    cbm_pkg::t_state                r_state, n_state;
    logic [cbm_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic                           r_sel, n_sel;
    logic                           r_ovalid, n_ovalid;
    logic                           out_load;

    assign out_load = (r_state == cbm_pkg::S_OUT) && (!r_ovalid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cbm_pkg::S_IDLE;
            r_cnt    <= '0;
            r_sel    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_sel    <= n_sel;
            r_ovalid <= n_ovalid;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        case (r_state)
            cbm_pkg::S_IDLE:  if (i_valid) n_state = cbm_pkg::S_DX;
            cbm_pkg::S_DX:    n_state = cbm_pkg::S_DY;
            cbm_pkg::S_DY:    n_state = cbm_pkg::S_MOD;
            cbm_pkg::S_MOD: begin
                if (r_cnt == cbm_pkg::CNT_W'(MOD_STEPS - 1)) n_state = cbm_pkg::S_FIX;
            end
            cbm_pkg::S_FIX: begin
                n_state = cbm_pkg::S_CINIT;
                n_sel   = 1'b0;
            end
            cbm_pkg::S_CINIT: n_state = cbm_pkg::S_CSTEP;
            cbm_pkg::S_CSTEP: begin
                if (r_cnt == cbm_pkg::CNT_W'(NSTEPS - 1)) n_state = cbm_pkg::S_CSAVE;
            end
            cbm_pkg::S_CSAVE: begin
                if (r_sel) begin
                    n_state = cbm_pkg::S_MUL;
                end else begin
                    n_state = cbm_pkg::S_CINIT;
                    n_sel   = 1'b1;
                end
            end
            cbm_pkg::S_MUL:   if (r_cnt == cbm_pkg::CNT_W'(4)) n_state = cbm_pkg::S_OUT;
            cbm_pkg::S_OUT:   if (out_load) n_state = cbm_pkg::S_IDLE;
            default:          n_state = cbm_pkg::S_IDLE;
        endcase
        n_cnt = (n_state != r_state) ? '0 : r_cnt + 1'b1;
        if (out_load)
            n_ovalid = 1'b1;
        else if (i_ready)
            n_ovalid = 1'b0;
        else
            n_ovalid = r_ovalid;
    end

    // outputs
    always_comb begin
        o_cmd           = '0;
        o_cmd.idx       = r_cnt;
        o_cmd.sel_pitch = r_sel;
        o_cmd.out_load  = out_load;
        o_ready         = 1'b0;
        case (r_state)
            cbm_pkg::S_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_valid;
            end
            cbm_pkg::S_DX:    o_cmd.dx       = 1'b1;
            cbm_pkg::S_DY:    o_cmd.dy       = 1'b1;
            cbm_pkg::S_MOD:   o_cmd.mod_step = 1'b1;
            cbm_pkg::S_FIX:   o_cmd.fix      = 1'b1;
            cbm_pkg::S_CINIT: o_cmd.cinit    = 1'b1;
            cbm_pkg::S_CSTEP: o_cmd.cstep    = 1'b1;
            cbm_pkg::S_CSAVE: o_cmd.csave    = 1'b1;
            cbm_pkg::S_MUL:   o_cmd.mul      = 1'b1;
            default:          o_ready        = 1'b0;
        endcase
    end

    assign o_valid = r_ovalid;

endmodule

[hdl/cbm_dp.sv]
module cbm_dp #(
    parameter int ANGLE_FRAC_BITS  = 8,
    parameter int VECTOR_FRAC_BITS = 14,
    parameter int SW               = 31
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  cbm_pkg::t_cmd                      i_cmd,
    input  logic [12:0]                        i_cursor_x,
    input  logic [12:0]                        i_cursor_y,
    input  logic                               i_cfg_valid,
    input  logic [1:0]                         i_cfg_index,
    input  logic [15:0]                        i_cfg_data,
    output logic signed [VECTOR_FRAC_BITS+1:0] o_front_x,
    output logic signed [VECTOR_FRAC_BITS+1:0] o_front_y,
    output logic signed [VECTOR_FRAC_BITS+1:0] o_front_z,
    output logic signed [VECTOR_FRAC_BITS+1:0] o_right_x,
    output logic signed [VECTOR_FRAC_BITS+1:0] o_right_z,
    output logic signed [VECTOR_FRAC_BITS+1:0] o_up_x,
    output logic signed [VECTOR_FRAC_BITS+1:0] o_up_y,
    output logic signed [VECTOR_FRAC_BITS+1:0] o_up_z,
    output logic [ANGLE_FRAC_BITS+8:0]         o_yaw_angle,
    output logic signed [ANGLE_FRAC_BITS+7:0]  o_pitch_angle
);

    localparam int AFB  = ANGLE_FRAC_BITS;
    localparam int VFB  = VECTOR_FRAC_BITS;
    localparam int YW   = AFB + 9;
    localparam int PW   = AFB + 8;
    localparam int OW   = VFB + 2;
    localparam int SHL  = (AFB >= 8) ? AFB - 8 : 0;
    localparam int SHR  = (AFB < 8) ? 8 - AFB : 0;
    localparam int ZSH  = cbm_pkg::CORDIC_FRAC - AFB;
    // yaw wrap: a full turn is 45 << LB, the low LB bits pass through and the
    // upper part is divided by 45 with a reciprocal multiply
    localparam int LB   = AFB + 3;
    localparam int UW   = SW - 1 - LB;
    localparam int RK   = UW + 6;
    localparam int MW   = RK - 5;
    localparam int QW   = UW - 5;
    localparam logic [MW-1:0] RECIP  = MW'(((64'd1 << RK) + 64'd44) / 64'd45);
    localparam logic [YW-1:0]        FULL    = YW'(360 * (2 ** AFB));
    localparam logic [YW-1:0]        YAW_RST = YW'(270 * (2 ** AFB));
    localparam logic signed [SW-1:0] LIM     = SW'(89 * (2 ** AFB));
    localparam logic signed [31:0]   HALF    = 32'sd188743680;
    localparam logic signed [31:0]   QUARTER = 32'sd94371840;

    function automatic logic signed [OW-1:0] to_out(input logic signed [33:0] v);
        logic signed [35:0] t;
        logic signed [35:0] one;
        one = 36'sd1 <<< VFB;
        t   = (36'(v) + (36'sd1 <<< (cbm_pkg::VEC_INT - 1 - VFB)))
              >>> (cbm_pkg::VEC_INT - VFB);
        if (t > one)  t = one;
        if (t < -one) t = -one;
        return OW'(t);
    endfunction

    logic [11:0]             r_hw, r_hh;
    logic [15:0]             r_sens;
    logic [YW-1:0]           r_yaw;
    logic signed [PW-1:0]    r_pitch;
    logic [12:0]             r_cx, r_cy;
    logic                    r_neg;
    logic [SW-1:0]           r_rem;
    logic [QW-1:0]           r_q;
    logic signed [31:0]      r_z;
    logic signed [33:0]      r_x, r_y;
    logic                    r_cneg;
    logic signed [31:0]      r_sy, r_cy_v, r_sp, r_cp;
    logic signed [63:0]      r_prod;
    logic [1:0]              r_pidx;
    logic signed [OW-1:0]    r_res [4];

    // angle step from the cursor offset
    logic signed [13:0]      off;
    logic signed [30:0]      prod;
    logic signed [SW-1:0]    delta, ysum, psum, psat;
    logic [SW-1:0]           yabs;
    logic [UW+MW-1:0]        qprod;
    logic [SW-1:0]           qfull;
    logic signed [31:0]      zin, z1;
    logic                    zneg;
    logic signed [33:0]      dx_s, dy_s;
    logic signed [31:0]      at;
    logic signed [31:0]      sv, cv, ma, mb;
    logic signed [33:0]      pv;

    always_comb begin
        if (i_cmd.dy)
            off = $signed({2'b00, r_hh}) - $signed({1'b0, r_cy});
        else
            off = $signed({1'b0, r_cx}) - $signed({2'b00, r_hw});
        prod  = 31'(off) * $signed({15'd0, r_sens});
        delta = (SW'(prod) <<< SHL) >>> SHR;
        ysum  = $signed(SW'(r_yaw)) + delta;
        yabs  = ysum[SW-1] ? SW'(-ysum) : SW'(ysum);
        psum  = SW'(r_pitch) + delta;
        if (psum > LIM)
            psat = LIM;
        else if (psum < -LIM)
            psat = -LIM;
        else
            psat = psum;
        qprod = (UW+MW)'(r_rem[SW-2:LB]) * (UW+MW)'(RECIP);
        qfull = SW'(r_q) * SW'(FULL);

        // fold the angle into plus or minus 90 degrees
        if (i_cmd.sel_pitch)
            zin = 32'(r_pitch) <<< ZSH;
        else
            zin = $signed(32'(r_yaw)) <<< ZSH;
        z1 = zin;
        if (z1 > HALF)   z1 = z1 - 2 * HALF;
        if (z1 <= -HALF) z1 = z1 + 2 * HALF;
        zneg = 1'b0;
        if (z1 > QUARTER) begin
            z1   = z1 - HALF;
            zneg = 1'b1;
        end else if (z1 < -QUARTER) begin
            z1   = z1 + HALF;
            zneg = 1'b1;
        end

        dx_s = r_y >>> i_cmd.idx;
        dy_s = r_x >>> i_cmd.idx;
        at   = $signed({5'd0, cbm_pkg::atan_q20(i_cmd.idx)});
        sv   = r_cneg ? 32'(-r_y) : 32'(r_y);
        cv   = r_cneg ? 32'(-r_x) : 32'(r_x);

        case (i_cmd.idx[1:0])
            2'd0:    begin ma = r_cy_v; mb = r_cp; end
            2'd1:    begin ma = r_sy;   mb = r_cp; end
            2'd2:    begin ma = r_cy_v; mb = r_sp; end
            default: begin ma = r_sy;   mb = r_sp; end
        endcase
        pv = 34'(r_prod >>> cbm_pkg::VEC_INT);
        if (r_pidx[1]) pv = -pv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hw    <= 12'd400;
            r_hh    <= 12'd300;
            r_sens  <= 16'd26;
            r_yaw   <= YAW_RST;
            r_pitch <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    cbm_pkg::CFG_HALF_WIDTH:  r_hw   <= i_cfg_data[11:0];
                    cbm_pkg::CFG_HALF_HEIGHT: r_hh   <= i_cfg_data[11:0];
                    cbm_pkg::CFG_SENSITIVITY: r_sens <= i_cfg_data;
                    default:                  r_sens <= r_sens;
                endcase
            end
            if (i_cmd.dy)  r_pitch <= PW'(psat);
            if (i_cmd.fix) r_yaw   <= (r_neg && r_rem != '0) ? FULL - YW'(r_rem) : YW'(r_rem);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cx <= i_cursor_x;
            r_cy <= i_cursor_y;
        end
        if (i_cmd.dx) begin
            r_neg <= ysum[SW-1];
            r_rem <= yabs;
        end
        // first step: quotient of the turns, second step: remainder
        if (i_cmd.mod_step && !i_cmd.idx[0])
            r_q <= qprod[UW+MW-1:RK];
        if (i_cmd.mod_step && i_cmd.idx[0])
            r_rem <= r_rem - qfull;
        if (i_cmd.cinit) begin
            r_z    <= z1;
            r_x    <= cbm_pkg::GAIN_Q30;
            r_y    <= '0;
            r_cneg <= zneg;
        end
        if (i_cmd.cstep) begin
            if (!r_z[31]) begin
                r_x <= r_x - dx_s;
                r_y <= r_y + dy_s;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + dx_s;
                r_y <= r_y - dy_s;
                r_z <= r_z + at;
            end
        end
        if (i_cmd.csave) begin
            if (i_cmd.sel_pitch) begin
                r_sp <= sv;
                r_cp <= cv;
            end else begin
                r_sy   <= sv;
                r_cy_v <= cv;
            end
        end
        if (i_cmd.mul) begin
            r_prod <= ma * mb;
            r_pidx <= i_cmd.idx[1:0];
            if (i_cmd.idx != '0) r_res[r_pidx] <= to_out(pv);
        end
        if (i_cmd.out_load) begin
            o_front_x     <= r_res[0];
            o_front_z     <= r_res[1];
            o_up_x        <= r_res[2];
            o_up_z        <= r_res[3];
            o_front_y     <= to_out(34'(r_sp));
            o_right_x     <= to_out(-34'(r_sy));
            o_right_z     <= to_out(34'(r_cy_v));
            o_up_y        <= to_out(34'(r_cp));
            o_yaw_angle   <= r_yaw;
            o_pitch_angle <= r_pitch;
        end
    end

endmodule

[hdl/camera_basis_from_mouse.sv]
// channel  | direction | handshake                  | payload
// input    | in        | i_valid / o_ready          | i_cursor_x, i_cursor_y
// result   | out       | o_valid / i_ready          | o_front_*, o_right_*, o_up_*, angles
// config   | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// one word at a time: a new word is taken only once the last result has been
// loaded into the output register; a single shared cordic stage runs once for
// yaw and once for pitch, after a yaw wrap of a quotient and a remainder step
// reset (synchronous, active low) restores the control state and settings, yaw 270 deg, pitch 0
// a finished result waits in the output register; the next word is accepted
// while it waits, and its result holds the input off until the register frees
module camera_basis_from_mouse #(
    parameter int ANGLE_FRAC_BITS  = 8,
    parameter int VECTOR_FRAC_BITS = 14,
    parameter int CORDIC_STEPS     = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input words
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [12:0]                        i_cursor_x,
    input  logic [12:0]                        i_cursor_y,
    // result words
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [VECTOR_FRAC_BITS+1:0] o_front_x,
    output logic signed [VECTOR_FRAC_BITS+1:0] o_front_y,
    output logic signed [VECTOR_FRAC_BITS+1:0] o_front_z,
    output logic signed [VECTOR_FRAC_BITS+1:0] o_right_x,
    output logic signed [VECTOR_FRAC_BITS+1:0] o_right_z,
    output logic signed [VECTOR_FRAC_BITS+1:0] o_up_x,
    output logic signed [VECTOR_FRAC_BITS+1:0] o_up_y,
    output logic signed [VECTOR_FRAC_BITS+1:0] o_up_z,
    output logic [ANGLE_FRAC_BITS+8:0]         o_yaw_angle,
    output logic signed [ANGLE_FRAC_BITS+7:0]  o_pitch_angle,
    // register writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [1:0]                         i_cfg_index,
    input  logic [15:0]                        i_cfg_data
);

    // width of the scaled angle step and of the sum with the stored angle
    localparam int DW = 30 + ((ANGLE_FRAC_BITS > 8) ? ANGLE_FRAC_BITS - 8 : 0);
    localparam int SW = DW + 1;
    // yaw wrap: quotient first, remainder in the next cycle
    localparam int MOD_STEPS = 2;
    localparam int NSTEPS    = (CORDIC_STEPS > cbm_pkg::ATAN_LEN) ?
                               cbm_pkg::ATAN_LEN : CORDIC_STEPS;

    cbm_pkg::t_cmd cmd;

    // registers are always writable; the user must send writes only while idle, the block does not enforce it
    assign o_cfg_ready = 1'b1;

    cbm_ctrl #(
        .MOD_STEPS (MOD_STEPS),
        .NSTEPS    (NSTEPS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd)
    );

    cbm_dp #(
        .ANGLE_FRAC_BITS  (ANGLE_FRAC_BITS),
        .VECTOR_FRAC_BITS (VECTOR_FRAC_BITS),
        .SW               (SW)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cursor_x    (i_cursor_x),
        .i_cursor_y    (i_cursor_y),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_front_x     (o_front_x),
        .o_front_y     (o_front_y),
        .o_front_z     (o_front_z),
        .o_right_x     (o_right_x),
        .o_right_z     (o_right_z),
        .o_up_x        (o_up_x),
        .o_up_y        (o_up_y),
        .o_up_z        (o_up_z),
        .o_yaw_angle   (o_yaw_angle),
        .o_pitch_angle (o_pitch_angle)
    );

endmodule
